@@ hdl/ifd_pkg.sv @@
// shared types, register indexes, parse phase codes and reset values for the deframer
package ifd_pkg;

   // default payload limit
   localparam int MAX_PAYLOAD_DEF = 1024;

   // register indexes on the csr port
   localparam logic [2:0] CSR_FLAG_BYTE   = 3'd0;
   localparam logic [2:0] CSR_ESCAPE_BYTE = 3'd1;
   localparam logic [2:0] CSR_SENDER_ADDR = 3'd2;
   localparam logic [2:0] CSR_CTRL_ZERO   = 3'd3;
   localparam logic [2:0] CSR_CTRL_ONE    = 3'd4;

   // register reset values
   localparam logic [7:0] FLAG_BYTE_RST   = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE_RST = 8'h7D;
   localparam logic [7:0] SENDER_ADDR_RST = 8'h03;
   localparam logic [7:0] CTRL_ZERO_RST   = 8'h00;
   localparam logic [7:0] CTRL_ONE_RST    = 8'h40;

   // xor applied to the byte after an escape
   localparam logic [7:0] STUFF_XOR = 8'h20;

   // parse phases
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_FLAG = 3'd1;
   localparam logic [2:0] PH_ADDR = 3'd2;
   localparam logic [2:0] PH_CTRL = 3'd3;
   localparam logic [2:0] PH_BODY = 3'd4;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] escape_byte;
      logic [7:0] sender_address;
      logic [7:0] info_control_zero;
      logic [7:0] info_control_one;
   } ifd_cfg_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic       frame_accepted;
      logic       ack_sequence;
      logic       frame_sequence;
   } ifd_result_type;

endpackage

@@ hdl/info_frame_deframer.sv @@
// top level of the byte-stuffed information frame deframer
// Receive side of a flag-delimited, byte-stuffed link layer. Raw line bytes enter
// on the req_ channel one item per cycle while rsp_ takes its results, with no
// bubbles needed between them. Each byte is first captured in an input register;
// once the output slot can move, the parse state (header hunt, destuffing, trailer
// hold-back, xor check) is updated in a single pass and any result is loaded into
// the rsp_ output register. The block sustains one byte per cycle while rsp_ does
// not stall; the limit is the single-pass parse state update. While a result waits
// on rsp_ the parse state holds, and the input register takes at most one more
// byte before req_ready drops. Results: payload bytes (result_kind 0), delayed by
// one body byte because the last destuffed byte is the xor trailer, and one verdict
// per frame at the closing flag (result_kind 1) with RR/REJ, receiver sequence bit,
// frame sequence bit and saturated payload length. Downstream drops the payload of
// a rejected frame. The user must write registers on csr_ only while the block is
// idle; the block itself does not enforce this.
module info_frame_deframer #(
   parameter int MAX_PAYLOAD = ifd_pkg::MAX_PAYLOAD_DEF,
   parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic             clock,
   input  logic             reset,
   // csr write port
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   // raw line bytes
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   // payload bytes and verdicts
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_frame_accepted,
   output logic             rsp_ack_sequence,
   output logic             rsp_frame_sequence,
   output logic [LEN_W-1:0] rsp_payload_length
);
   import ifd_pkg::*;

   // configuration registers
   ifd_cfg_type cfg_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // output register
   logic             out_valid_ff, out_valid_in;
   ifd_result_type   out_res_ff;
   logic [LEN_W-1:0] out_len_ff;

   // engine results
   logic             eng_valid;
   ifd_result_type   eng_res;
   logic [LEN_W-1:0] eng_len;

   logic accept;
   logic advance;
   logic step;

   // output slot is free or being emptied this cycle
   assign advance   = !out_valid_ff || rsp_ready;
   // the byte in the input register is processed when the output slot can move
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)    in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = eng_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte         <= FLAG_BYTE_RST;
         cfg_ff.escape_byte       <= ESCAPE_BYTE_RST;
         cfg_ff.sender_address    <= SENDER_ADDR_RST;
         cfg_ff.info_control_zero <= CTRL_ZERO_RST;
         cfg_ff.info_control_one  <= CTRL_ONE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FLAG_BYTE:   cfg_ff.flag_byte         <= csr_wdata;
            CSR_ESCAPE_BYTE: cfg_ff.escape_byte       <= csr_wdata;
            CSR_SENDER_ADDR: cfg_ff.sender_address    <= csr_wdata;
            CSR_CTRL_ZERO:   cfg_ff.info_control_zero <= csr_wdata;
            CSR_CTRL_ONE:    cfg_ff.info_control_one  <= csr_wdata;
            default:         ; // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) in_byte_ff <= req_rx_byte;
      if (eng_valid) begin
         out_res_ff <= eng_res;
         out_len_ff <= eng_len;
      end
   end

   ifd_engine #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .res_valid  (eng_valid),
      .res        (eng_res),
      .res_length (eng_len)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_res_ff.result_kind;
   assign rsp_payload_byte   = out_res_ff.payload_byte;
   assign rsp_frame_accepted = out_res_ff.frame_accepted;
   assign rsp_ack_sequence   = out_res_ff.ack_sequence;
   assign rsp_frame_sequence = out_res_ff.frame_sequence;
   assign rsp_payload_length = out_len_ff;

endmodule

@@ hdl/ifd_engine.sv @@
// parse state machine, destuffing, trailer hold-back and verdict logic
module ifd_engine #(
   parameter int MAX_PAYLOAD = ifd_pkg::MAX_PAYLOAD_DEF,
   parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ifd_pkg::ifd_cfg_type   cfg,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   output logic                   res_valid,
   output ifd_pkg::ifd_result_type res,
   output logic [LEN_W-1:0]       res_length
);
   import ifd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

   logic [2:0]       phase_ff,   phase_in;
   logic [7:0]       ctrl_ff,    ctrl_in;
   logic [7:0]       held_ff,    held_in;
   logic             hv_ff,      hv_in;
   logic             esc_ff,     esc_in;
   logic [7:0]       par_ff,     par_in;
   logic [CNT_W-1:0] cnt_ff,     cnt_in;
   logic             rseq_ff,    rseq_in;

   logic       ok;
   logic       take;
   logic [7:0] data;
   logic       emit;

   assign ok = hv_ff && !esc_ff && (cnt_ff <= MAX_CNT) && (par_ff == held_ff);

   always_comb begin
      phase_in   = phase_ff;
      ctrl_in    = ctrl_ff;
      held_in    = held_ff;
      hv_in      = hv_ff;
      esc_in     = esc_ff;
      par_in     = par_ff;
      cnt_in     = cnt_ff;
      rseq_in    = rseq_ff;
      emit       = 1'b0;
      res        = '0;
      res_length = '0;
      take       = 1'b0;
      data       = rx_byte;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.flag_byte) phase_in = PH_FLAG;
         end
         PH_FLAG: begin
            if (rx_byte == cfg.sender_address)  phase_in = PH_ADDR;
            else if (rx_byte == cfg.flag_byte)  phase_in = PH_FLAG;
            else                                phase_in = PH_HUNT;
         end
         PH_ADDR: begin
            if (rx_byte == cfg.info_control_zero || rx_byte == cfg.info_control_one) begin
               ctrl_in  = rx_byte;
               phase_in = PH_CTRL;
            end else if (rx_byte == cfg.flag_byte) begin
               phase_in = PH_FLAG;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_CTRL: begin
            if (rx_byte == (ctrl_ff ^ cfg.sender_address)) begin
               held_in  = '0;
               hv_in    = 1'b0;
               esc_in   = 1'b0;
               par_in   = '0;
               cnt_in   = '0;
               phase_in = PH_BODY;
            end else if (rx_byte == cfg.flag_byte) begin
               phase_in = PH_FLAG;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_BODY: begin
            if (rx_byte == cfg.flag_byte) begin
               // closing flag: verdict, then hunt for a new opening flag
               emit               = 1'b1;
               res.result_kind    = KIND_VERDICT;
               res.frame_accepted = ok;
               res.ack_sequence   = rseq_ff;
               res.frame_sequence = (ctrl_ff != cfg.info_control_zero) &&
                                    (ctrl_ff == cfg.info_control_one);
               res_length         = (cnt_ff > MAX_CNT) ? LEN_W'(MAX_PAYLOAD)
                                                       : cnt_ff[LEN_W-1:0];
               if (ok) rseq_in = ~rseq_ff;
               phase_in = PH_HUNT;
               held_in  = '0;
               hv_in    = 1'b0;
               esc_in   = 1'b0;
               par_in   = '0;
               cnt_in   = '0;
            end else if (esc_ff) begin
               data   = rx_byte ^ STUFF_XOR;
               esc_in = 1'b0;
               take   = 1'b1;
            end else if (rx_byte == cfg.escape_byte) begin
               esc_in = 1'b1;
            end else begin
               take = 1'b1;
            end
            if (take) begin
               // release the byte held back, keep the new one as possible trailer
               if (hv_ff) begin
                  emit             = 1'b1;
                  res.result_kind  = KIND_PAYLOAD;
                  res.payload_byte = held_ff;
                  par_in           = par_ff ^ held_ff;
                  if (cnt_ff <= MAX_CNT) cnt_in = cnt_ff + 1'b1;
               end
               held_in = data;
               hv_in   = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   assign res_valid = step && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         ctrl_ff  <= '0;
         held_ff  <= '0;
         hv_ff    <= 1'b0;
         esc_ff   <= 1'b0;
         par_ff   <= '0;
         cnt_ff   <= '0;
         rseq_ff  <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         ctrl_ff  <= ctrl_in;
         held_ff  <= held_in;
         hv_ff    <= hv_in;
         esc_ff   <= esc_in;
         par_ff   <= par_in;
         cnt_ff   <= cnt_in;
         rseq_ff  <= rseq_in;
      end
   end

endmodule

@@ sim/tb_info_frame_deframer.sv @@
// self-checking testbench for the byte-stuffed information frame deframer
`timescale 1ns / 100ps

module tb_info_frame_deframer;
   import ifd_pkg::*;

   localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;
   localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

   // first csr index past the register list, writes there must change nothing
   localparam logic [2:0] CSR_UNUSED = 3'd5;

   // run shape
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 70;
   localparam int IDLE_PCT     = 31;
   localparam int CALM_FROM    = 1200;
   localparam int CALM_TO      = 2400;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // one result as the block reports it
   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic             accepted;
      logic             ack_seq;
      logic             frame_seq;
      logic [LEN_W-1:0] length;
   } deframe_result_type;

   // one line byte plus an optional typed-in result
   typedef struct packed {
      logic [7:0]         rx_byte;
      logic               typed;
      deframe_result_type want;
   } stim_row_type;

   // ways a random frame gets broken
   typedef enum int {
      FAULT_NONE,
      FAULT_NO_OPEN,
      FAULT_ADDR,
      FAULT_CHECK,
      FAULT_TRAILER,
      FAULT_ESCAPE,
      FAULT_EMPTY,
      FAULT_CUT
   } frame_fault_type;

   localparam logic [23:0] NO_CHECK = '0;

   // directed frames under reset register values (flag 7e, escape 7d, address 03,
   // control 00 / 40); verdicts and payload bytes are typed in
   localparam stim_row_type DIRECTED [27] = '{
      // trailer only, trailer zero: accept with zero length, receiver bit 1
      {8'h7E, NO_CHECK}, {8'h03, NO_CHECK}, {8'h00, NO_CHECK}, {8'h03, NO_CHECK},
      {8'h00, NO_CHECK},
      {8'h7E, 1'b1, KIND_VERDICT, 8'h00, 1'b1, 1'b1, 1'b0, 11'd0},
      // empty body, sequence 1 control: reject
      {8'h7E, NO_CHECK}, {8'h03, NO_CHECK}, {8'h40, NO_CHECK}, {8'h43, NO_CHECK},
      {8'h7E, 1'b1, KIND_VERDICT, 8'h00, 1'b0, 1'b0, 1'b1, 11'd0},
      // payload ff and a stuffed flag, trailer 81: accept with length 2
      {8'h7E, NO_CHECK}, {8'h03, NO_CHECK}, {8'h40, NO_CHECK}, {8'h43, NO_CHECK},
      {8'hFF, NO_CHECK}, {8'h7D, NO_CHECK},
      {8'h5E, 1'b1, KIND_PAYLOAD, 8'hFF, 1'b0, 1'b0, 1'b0, 11'd0},
      {8'h81, 1'b1, KIND_PAYLOAD, 8'h7E, 1'b0, 1'b0, 1'b0, 11'd0},
      {8'h7E, 1'b1, KIND_VERDICT, 8'h00, 1'b1, 1'b0, 1'b1, 11'd2},
      // escape right before the closing flag: reject
      {8'h7E, NO_CHECK}, {8'h03, NO_CHECK}, {8'h00, NO_CHECK}, {8'h03, NO_CHECK},
      {8'h55, NO_CHECK}, {8'h7D, NO_CHECK},
      {8'h7E, 1'b1, KIND_VERDICT, 8'h00, 1'b0, 1'b1, 1'b0, 11'd0}
   };

   // fixed register settings: reset values, two extreme mixes with
   // coinciding values, and everything zero
   localparam ifd_cfg_type CFG_TABLE [4] = '{
      {FLAG_BYTE_RST, ESCAPE_BYTE_RST, SENDER_ADDR_RST, CTRL_ZERO_RST, CTRL_ONE_RST},
      {8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF},
      {8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00},
      {8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // dut ports, with every input driven to a known value from time zero
   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             csr_write_en = 1'b0;
   logic [2:0]       csr_index    = '0;
   logic [7:0]       csr_wdata    = '0;
   logic             req_valid    = 1'b0;
   logic             req_ready;
   logic [7:0]       req_rx_byte  = '0;
   logic             rsp_valid;
   logic             rsp_ready    = 1'b0;
   logic             rsp_result_kind;
   logic [7:0]       rsp_payload_byte;
   logic             rsp_frame_accepted;
   logic             rsp_ack_sequence;
   logic             rsp_frame_sequence;
   logic [LEN_W-1:0] rsp_payload_length;

   info_frame_deframer #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_ack_sequence   (rsp_ack_sequence),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_payload_length (rsp_payload_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // line bytes waiting to be sent, and results still owed by the block
   stim_row_type       line_q[$];
   deframe_result_type result_q[$];
   stim_row_type       cur_row;

   int  mismatches  = 0;
   int  cycle_count = 0;
   int  phase_items = 0;
   // no idling on either side inside this window
   wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   // ------------------------------------------------------------------
   // deframer predictor: own copy of the registers and the parse state
   // ------------------------------------------------------------------
   ifd_cfg_type cfg = CFG_TABLE[0];

   logic [2:0] rx_phase   = PH_HUNT;
   logic [7:0] ctrl_seen  = '0;
   logic [7:0] hold_byte  = '0;
   logic       hold_valid = 1'b0;
   logic       esc_pend   = 1'b0;
   logic [7:0] body_xor   = '0;
   int         body_cnt   = 0;      // saturates one past the payload limit
   logic       rr_seq     = 1'b1;   // receiver sequence bit

   function automatic void drop_body();
      hold_byte  = '0;
      hold_valid = 1'b0;
      esc_pend   = 1'b0;
      body_xor   = '0;
      body_cnt   = 0;
   endfunction

   // advance the predictor by one line byte, returns 1 when a result comes out
   function automatic bit deframe_byte(input logic [7:0] b, output deframe_result_type r);
      logic [7:0] d;
      bit         good;
      bit         emit;
      r    = '0;
      emit = 1'b0;
      case (rx_phase)
         PH_HUNT: begin
            if (b == cfg.flag_byte) rx_phase = PH_FLAG;
            return 1'b0;
         end
         PH_FLAG: begin
            // address wins over the flag when the two coincide
            if (b == cfg.sender_address) rx_phase = PH_ADDR;
            else if (b == cfg.flag_byte) rx_phase = PH_FLAG;
            else rx_phase = PH_HUNT;
            return 1'b0;
         end
         PH_ADDR: begin
            if (b == cfg.info_control_zero || b == cfg.info_control_one) begin
               ctrl_seen = b;
               rx_phase  = PH_CTRL;
            end else if (b == cfg.flag_byte) rx_phase = PH_FLAG;
            else rx_phase = PH_HUNT;
            return 1'b0;
         end
         PH_CTRL: begin
            if (b == (ctrl_seen ^ cfg.sender_address)) begin
               drop_body();
               rx_phase = PH_BODY;
            end else if (b == cfg.flag_byte) rx_phase = PH_FLAG;
            else rx_phase = PH_HUNT;
            return 1'b0;
         end
         PH_BODY: ;
         default: begin
            rx_phase = PH_HUNT;
            return 1'b0;
         end
      endcase

      // closing flag: verdict, then hunt for a fresh opening flag
      if (b == cfg.flag_byte) begin
         good = hold_valid && !esc_pend && (body_cnt <= MAX_PAYLOAD) &&
                (body_xor == hold_byte);
         r.kind      = KIND_VERDICT;
         r.accepted  = good;
         r.ack_seq   = rr_seq;
         r.frame_seq = (ctrl_seen != cfg.info_control_zero) &&
                       (ctrl_seen == cfg.info_control_one);
         r.length    = (body_cnt > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(body_cnt);
         if (good) rr_seq = ~rr_seq;
         rx_phase = PH_HUNT;
         drop_body();
         return 1'b1;
      end

      // destuffing
      if (esc_pend) begin
         d        = b ^ STUFF_XOR;
         esc_pend = 1'b0;
      end else if (b == cfg.escape_byte) begin
         esc_pend = 1'b1;
         return 1'b0;
      end else begin
         d = b;
      end

      // the newest byte may be the trailer, so only the one before it comes out
      if (hold_valid) begin
         r.kind   = KIND_PAYLOAD;
         r.data   = hold_byte;
         body_xor = body_xor ^ hold_byte;
         if (body_cnt <= MAX_PAYLOAD) body_cnt++;
         emit = 1'b1;
      end
      hold_byte  = d;
      hold_valid = 1'b1;
      return emit;
   endfunction

   // ------------------------------------------------------------------
   // line side: sends queued bytes, random gaps, predicts on acceptance
   // ------------------------------------------------------------------
   always @(posedge clock) begin : line_driver
      deframe_result_type res;
      bit                 hit;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            hit = deframe_byte(cur_row.rx_byte, res);
            // a typed-in row stands in for the predictor's result
            if (cur_row.typed) result_q.push_back(cur_row.want);
            else if (hit) result_q.push_back(res);
         end
         if (!req_valid || req_ready) begin
            if (line_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               cur_row = line_q.pop_front();
               req_valid   <= 1'b1;
               req_rx_byte <= cur_row.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side stalls at random outside the calm window
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic check_field(input string what, input logic [10:0] want,
                              input logic [10:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // every accepted result is compared with the oldest one owed
   always @(posedge clock) begin : result_check
      deframe_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_q.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual kind %0d byte %h",
                     $time, rsp_result_kind, rsp_payload_byte);
            mismatches++;
         end else begin
            want = result_q.pop_front();
            check_field("result_kind", 11'(want.kind), 11'(rsp_result_kind));
            check_field("payload_byte", 11'(want.data), 11'(rsp_payload_byte));
            check_field("frame_accepted", 11'(want.accepted), 11'(rsp_frame_accepted));
            check_field("ack_sequence", 11'(want.ack_seq), 11'(rsp_ack_sequence));
            check_field("frame_sequence", 11'(want.frame_seq), 11'(rsp_frame_sequence));
            check_field("payload_length", 11'(want.length), 11'(rsp_payload_length));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // register writes, only while the block is idle
   // ------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         CSR_FLAG_BYTE:   cfg.flag_byte         = val;
         CSR_ESCAPE_BYTE: cfg.escape_byte       = val;
         CSR_SENDER_ADDR: cfg.sender_address    = val;
         CSR_CTRL_ZERO:   cfg.info_control_zero = val;
         CSR_CTRL_ONE:    cfg.info_control_one  = val;
         default: ;
      endcase
   endtask

   task automatic apply_cfg(input ifd_cfg_type c);
      csr_write(CSR_FLAG_BYTE, c.flag_byte);
      csr_write(CSR_ESCAPE_BYTE, c.escape_byte);
      csr_write(CSR_SENDER_ADDR, c.sender_address);
      csr_write(CSR_CTRL_ZERO, c.info_control_zero);
      csr_write(CSR_CTRL_ONE, c.info_control_one);
      // unknown index, must be ignored
      csr_write(CSR_UNUSED, 8'($urandom_range(255)));
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // wait until every byte went in and every result came out, then let the
   // pipeline run dry since a byte may leave no result behind
   task automatic settle();
      do @(negedge clock);
      while (line_q.size() != 0 || req_valid || result_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // random frame builder
   // ------------------------------------------------------------------
   task automatic queue_line_byte(input logic [7:0] b);
      stim_row_type r;
      r         = '0;
      r.rx_byte = b;
      line_q.push_back(r);
      phase_items++;
   endtask

   // flag and escape must be stuffed, other bytes now and then too
   task automatic queue_body_byte(input logic [7:0] b);
      if (b == cfg.flag_byte || b == cfg.escape_byte || $urandom_range(15) == 0) begin
         queue_line_byte(cfg.escape_byte);
         queue_line_byte(b ^ STUFF_XOR);
      end else begin
         queue_line_byte(b);
      end
   endtask

   task automatic queue_frame(input int len, input frame_fault_type fault);
      logic [7:0] ctrl;
      logic [7:0] addr;
      logic [7:0] sum;
      logic [7:0] b;
      bit         cut_early;
      ctrl      = $urandom_range(1) ? cfg.info_control_one : cfg.info_control_zero;
      addr      = (fault == FAULT_ADDR) ? 8'($urandom_range(255)) : cfg.sender_address;
      cut_early = ($urandom_range(1) == 1);
      // no opening flag: the last closing flag must not open this frame
      if (fault != FAULT_NO_OPEN) queue_line_byte(cfg.flag_byte);
      if ($urandom_range(7) == 0) queue_line_byte(cfg.flag_byte);
      queue_line_byte(addr);
      // a flag inside the header starts it over
      if (fault == FAULT_CUT && cut_early) begin
         queue_line_byte(cfg.flag_byte);
         queue_line_byte(addr);
      end
      queue_line_byte(ctrl);
      if (fault == FAULT_CUT && !cut_early) begin
         queue_line_byte(cfg.flag_byte);
         queue_line_byte(addr);
         queue_line_byte(ctrl);
      end
      if (fault == FAULT_CHECK) queue_line_byte(ctrl ^ addr ^ 8'($urandom_range(1, 255)));
      else queue_line_byte(ctrl ^ addr);
      if (fault != FAULT_EMPTY) begin
         sum = '0;
         repeat (len) begin
            case ($urandom_range(9))
               0:       b = cfg.flag_byte;
               1:       b = cfg.escape_byte;
               2:       b = 8'h00;
               3:       b = 8'hFF;
               default: b = 8'($urandom_range(255));
            endcase
            sum = sum ^ b;
            queue_body_byte(b);
         end
         if (fault == FAULT_TRAILER) queue_body_byte(sum ^ 8'($urandom_range(1, 255)));
         else queue_body_byte(sum);
      end
      if (fault == FAULT_ESCAPE) queue_line_byte(cfg.escape_byte);
      queue_line_byte(cfg.flag_byte);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      ifd_cfg_type     c;
      frame_fault_type fault;
      int              len;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed frames run on the reset register values
      foreach (DIRECTED[i]) line_q.push_back(DIRECTED[i]);
      settle();

      // random frames, one register setting per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < 4) begin
            c = CFG_TABLE[ph];
         end else begin
            c.flag_byte         = 8'($urandom_range(255));
            c.escape_byte       = 8'($urandom_range(255));
            c.sender_address    = 8'($urandom_range(255));
            c.info_control_zero = 8'($urandom_range(255));
            // now and then both controls coincide
            c.info_control_one  = ($urandom_range(7) == 0) ? c.info_control_zero
                                                           : 8'($urandom_range(255));
         end
         apply_cfg(c);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // line noise between frames
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 4)) queue_line_byte(8'($urandom_range(255)));
            end
            len   = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            fault = ($urandom_range(99) < 70) ? FAULT_NONE
                    : frame_fault_type'($urandom_range(FAULT_NO_OPEN, FAULT_CUT));
            queue_frame(len, fault);
         end
         settle();
      end

      // payload limit: past it the frame rejects with a saturated length
      apply_cfg(CFG_TABLE[0]);
      queue_frame(MAX_PAYLOAD + 2, FAULT_NONE);
      settle();

      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

@@ info_frame_deframer.f @@
hdl/ifd_pkg.sv
hdl/ifd_engine.sv
hdl/info_frame_deframer.sv
sim/tb_info_frame_deframer.sv
